[rtl/mbb_pkg.sv]
// shared types, codes and constants of the monochrome bitmap blitter
package mbb_pkg;

  localparam int DEF_SCREEN_COLUMNS = 128;
  localparam int DEF_SCREEN_PAGES   = 8;
  localparam int MARKS_PER_BYTE     = 8;
  localparam int ROWS_PER_PAGE      = 8;
  localparam logic [7:0] BIT0_MASK  = 8'h01;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_BITMAP = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OFFSCREEN = 2'd1,
    ST_NO_REGION = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK,
    S_DRAIN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cursor_cmd_t;

  typedef struct packed {
    logic       active;
    logic       region_end;
    logic       on_screen;
    logic       set_mode;
    logic [2:0] bit_pos;
  } cursor_sts_t;

  typedef struct packed {
    logic [7:0] data;
    logic       finished;
    status_t    status;
  } result_t;

endpackage

[rtl/mbb_ram.sv]
// generic single-write, single-read ram with registered read data
module mbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mbb_cursor.sv]
// region registers and walk cursor, pixel address generation
module mbb_cursor #(
  parameter int SCREEN_COLUMNS = mbb_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = mbb_pkg::DEF_SCREEN_PAGES,
  localparam int COL_W = $clog2(SCREEN_COLUMNS),
  localparam int PG_W  = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1,
  localparam int AW    = COL_W + PG_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbb_pkg::cursor_cmd_t cmd,
  input  logic [6:0]           origin_x,
  input  logic [5:0]           origin_y,
  input  logic [7:0]           region_width,
  input  logic [6:0]           region_height,
  input  logic                 set_pixels,
  output mbb_pkg::cursor_sts_t sts,
  output logic [AW-1:0]        pix_addr
);

  localparam int ROWS = SCREEN_PAGES * mbb_pkg::ROWS_PER_PAGE;

  logic [7:0] col_r;
  logic [6:0] row_r;
  logic [6:0] ox_r;
  logic [5:0] oy_r;
  logic [7:0] w_r;
  logic [6:0] h_r;
  logic       set_r;
  logic       active_r;

  logic [8:0] px;
  logic [8:0] py;
  logic [7:0] row_inc;
  logic [8:0] col_inc;
  logic       col_wrap;
  logic       last;

  assign px       = {2'b0, ox_r} + {1'b0, col_r};
  assign py       = {3'b0, oy_r} + {2'b0, row_r};
  assign row_inc  = {1'b0, row_r} + 8'd1;
  assign col_inc  = {1'b0, col_r} + 9'd1;
  assign col_wrap = row_inc >= {1'b0, h_r};
  assign last     = col_wrap && (col_inc >= {1'b0, w_r});

  assign pix_addr = {px[COL_W-1:0], py[3 +: PG_W]};

  assign sts.active     = active_r;
  assign sts.region_end = last;
  assign sts.on_screen  = (px < 9'(SCREEN_COLUMNS)) && (py < 9'(ROWS));
  assign sts.set_mode   = set_r;
  assign sts.bit_pos    = py[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      w_r      <= '0;
      h_r      <= '0;
      set_r    <= 1'b0;
      active_r <= 1'b0;
    end else if (cmd.load) begin
      col_r    <= '0;
      row_r    <= '0;
      ox_r     <= origin_x;
      oy_r     <= origin_y;
      w_r      <= region_width;
      h_r      <= region_height;
      set_r    <= set_pixels;
      active_r <= (region_width != '0) && (region_height != '0);
    end else if (cmd.step && active_r) begin
      if (col_wrap) begin
        row_r <= '0;
        col_r <= col_inc[7:0];
        if (last) begin
          active_r <= 1'b0;
        end
      end else begin
        row_r <= row_inc[6:0];
      end
    end
  end

endmodule

[rtl/mbb_ctrl.sv]
// sequencer: store clearing, per-pixel read-modify-write with forwarding, reads
module mbb_ctrl #(
  parameter int SCREEN_COLUMNS = mbb_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = mbb_pkg::DEF_SCREEN_PAGES,
  localparam int COL_W = $clog2(SCREEN_COLUMNS),
  localparam int PG_W  = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1,
  localparam int AW    = COL_W + PG_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_operation,
  input  logic [7:0]           in_region_width,
  input  logic [6:0]           in_region_height,
  input  logic [7:0]           in_bitmap_byte,
  input  logic [6:0]           in_read_column,
  input  logic [2:0]           in_read_page,
  output mbb_pkg::cursor_cmd_t cmd,
  input  mbb_pkg::cursor_sts_t sts,
  input  logic [AW-1:0]        pix_addr,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic [AW-1:0]        ram_raddr,
  input  logic [7:0]           ram_rdata,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mbb_pkg::result_t     res
);

  mbb_pkg::state_t  state_r, state_nxt;
  mbb_pkg::result_t res_r, res_nxt;

  logic [AW-1:0] clr_r;
  logic [7:0]    marks_r;
  logic [2:0]    cnt_r;
  logic          p_valid_r;
  logic          p_mark_r;
  logic [AW-1:0] p_addr_r;
  logic [2:0]    p_bit_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;

  logic          accept;
  logic [8:0]    rd_col;
  logic [3:0]    rd_page;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic [7:0]    cur_byte;
  logic [7:0]    bit_mask;
  logic [7:0]    mod_byte;

  assign accept   = in_valid && !in_stall;
  assign rd_col   = {2'b0, in_read_column};
  assign rd_page  = {1'b0, in_read_page};
  assign rd_ok    = (rd_col < 9'(SCREEN_COLUMNS)) && ({1'b0, rd_page} < 5'(SCREEN_PAGES));
  assign rd_addr  = {rd_col[COL_W-1:0], rd_page[PG_W-1:0]};
  assign cur_byte = fwd_r ? fwd_data_r : ram_rdata;
  assign bit_mask = mbb_pkg::BIT0_MASK << p_bit_r;
  assign mod_byte = sts.set_mode ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
  assign res      = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbb_pkg::S_CLEAR: begin
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = mbb_pkg::S_IDLE;
        end
      end
      mbb_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            mbb_pkg::OP_BITMAP: begin
              state_nxt = sts.active ? mbb_pkg::S_MARK : mbb_pkg::S_DONE;
            end
            mbb_pkg::OP_READ: begin
              state_nxt = rd_ok ? mbb_pkg::S_READ : mbb_pkg::S_DONE;
            end
            default: begin
              state_nxt = mbb_pkg::S_DONE;
            end
          endcase
        end
      end
      mbb_pkg::S_MARK: begin
        if (sts.region_end || cnt_r == 3'(mbb_pkg::MARKS_PER_BYTE - 1)) begin
          state_nxt = mbb_pkg::S_DRAIN;
        end
      end
      mbb_pkg::S_DRAIN: begin
        state_nxt = mbb_pkg::S_DONE;
      end
      mbb_pkg::S_READ: begin
        state_nxt = mbb_pkg::S_DONE;
      end
      mbb_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = mbb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mbb_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != mbb_pkg::S_IDLE);
    res_valid = (state_r == mbb_pkg::S_DONE);
    cmd.load  = (state_r == mbb_pkg::S_IDLE) && in_valid &&
                (in_operation == mbb_pkg::OP_START);
    cmd.step  = (state_r == mbb_pkg::S_MARK);
    ram_raddr = (state_r == mbb_pkg::S_MARK) ? pix_addr : rd_addr;
    ram_we    = 1'b0;
    ram_waddr = p_addr_r;
    ram_wdata = mod_byte;
    if (state_r == mbb_pkg::S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (p_valid_r && p_mark_r) begin
      ram_we = 1'b1;
    end
  end

  // result fields
  always_comb begin
    res_nxt = res_r;
    case (state_r)
      mbb_pkg::S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          case (in_operation)
            mbb_pkg::OP_START: begin
              res_nxt.finished = (in_region_width == '0) || (in_region_height == '0);
            end
            mbb_pkg::OP_BITMAP: begin
              if (!sts.active) begin
                res_nxt.status = mbb_pkg::ST_NO_REGION;
              end
            end
            mbb_pkg::OP_READ: begin
              if (!rd_ok) begin
                res_nxt.status = mbb_pkg::ST_OFFSCREEN;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      mbb_pkg::S_MARK: begin
        if (marks_r[0] && !sts.on_screen) begin
          res_nxt.status = mbb_pkg::ST_OFFSCREEN;
        end
        if (sts.region_end) begin
          res_nxt.finished = 1'b1;
        end
      end
      mbb_pkg::S_READ: begin
        res_nxt.data = cur_byte;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mbb_pkg::S_CLEAR;
      clr_r     <= '0;
      p_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= (state_r == mbb_pkg::S_MARK);
      fwd_r     <= ram_we && (ram_waddr == ram_raddr);
      if (state_r == mbb_pkg::S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == mbb_pkg::S_MARK) begin
        cnt_r <= cnt_r + 3'd1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    fwd_data_r <= ram_wdata;
    p_mark_r   <= marks_r[0] && sts.on_screen;
    p_addr_r   <= pix_addr;
    p_bit_r    <= sts.bit_pos;
    if (state_r == mbb_pkg::S_IDLE) begin
      marks_r <= in_bitmap_byte;
    end else if (state_r == mbb_pkg::S_MARK) begin
      marks_r <= {1'b0, marks_r[7:1]};
    end
  end

endmodule

[rtl/mbb_out_buf.sv]
// result register between the sequencer and the output channel
module mbb_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  mbb_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_stall,
  output mbb_pkg::result_t out_res
);

  logic             out_valid_r;
  mbb_pkg::result_t out_res_r;

  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

endmodule

[rtl/monochrome_bitmap_blitter_unit.sv]
// top level of the monochrome page-mode bitmap blitter
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  operation, region, bitmap byte, read address
//   out_     output     out_valid / out_stall read_data, region_finished, status
//
// after reset the frame store is swept to zero, one byte per cycle, in_stall high, all
// 2**(COL_W + PG_W) bytes (1024 by default)
// start, unused, region-less bitmap and off-screen read items go from idle straight to done,
// reads pass the read state, bitmap bytes with a region walk their marks in the mark state and
// drain: one read-modify-write of the single frame ram per mark, back to back with forwarding
// one item at a time; the result register lets the next item in while out_stall holds a result
module monochrome_bitmap_blitter_unit #(
  parameter int SCREEN_COLUMNS = mbb_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = mbb_pkg::DEF_SCREEN_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [6:0] in_origin_x,
  input  logic [5:0] in_origin_y,
  input  logic [7:0] in_region_width,
  input  logic [6:0] in_region_height,
  input  logic       in_set_pixels,
  input  logic [7:0] in_bitmap_byte,
  input  logic [6:0] in_read_column,
  input  logic [2:0] in_read_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_region_finished,
  output logic [1:0] out_status
);

  localparam int COL_W = $clog2(SCREEN_COLUMNS);
  localparam int PG_W  = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int AW    = COL_W + PG_W;
  localparam int DEPTH = 1 << AW;

  mbb_pkg::cursor_cmd_t cmd;
  mbb_pkg::cursor_sts_t sts;
  mbb_pkg::result_t     res;
  mbb_pkg::result_t     out_res;

  logic [AW-1:0] pix_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          res_valid;
  logic          res_ready;

  mbb_cursor #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .origin_x      (in_origin_x),
    .origin_y      (in_origin_y),
    .region_width  (in_region_width),
    .region_height (in_region_height),
    .set_pixels    (in_set_pixels),
    .sts           (sts),
    .pix_addr      (pix_addr)
  );

  mbb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mbb_ctrl #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_region_width  (in_region_width),
    .in_region_height (in_region_height),
    .in_bitmap_byte   (in_bitmap_byte),
    .in_read_column   (in_read_column),
    .in_read_page     (in_read_page),
    .cmd              (cmd),
    .sts              (sts),
    .pix_addr         (pix_addr),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  mbb_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_read_data       = out_res.data;
  assign out_region_finished = out_res.finished;
  assign out_status          = out_res.status;

endmodule

[rtl/mbb_checker.sv]
// port-level checker for the bitmap blitter, bound to the top level
module mbb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_region_finished,
  input logic [1:0] out_status
);

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
    $stable(out_region_finished) && $stable(out_status))
    else $error("stalled result changed");

  // one item in flight: the transfer cycle is followed by stall
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item was in flight");

  // store sweep blocks input right after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("input open during store clear");

  // only an in-range read returns nonzero data, never with a finished flag
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'd0 |->
    out_status == mbb_pkg::ST_OK && !out_region_finished)
    else $error("nonzero data on a non-read result");

  // a bitmap byte with no region never finishes one
  a_no_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mbb_pkg::ST_NO_REGION |-> !out_region_finished)
    else $error("finished flag with no active region");

endmodule

bind monochrome_bitmap_blitter_unit mbb_checker u_mbb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_read_data       (out_read_data),
  .out_region_finished (out_region_finished),
  .out_status          (out_status)
);

[tb/testbench.sv]
// self-checking testbench of the monochrome bitmap blitter with a framebuffer predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbb_pkg::*;

  localparam int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS;
  localparam int SCREEN_PAGES   = DEF_SCREEN_PAGES;
  localparam int SCREEN_ROWS    = SCREEN_PAGES * ROWS_PER_PAGE;
  localparam int HOLD_CYCLES    = 400;
  localparam int STUCK_LIMIT    = 8000;
  localparam int SETTLE_CYCLES  = 30;

  typedef struct {
    op_t        op;
    logic [6:0] origin_x;
    logic [5:0] origin_y;
    logic [7:0] width;
    logic [6:0] height;
    logic       set_mode;
    logic [7:0] marks;
    logic [6:0] column;
    logic [2:0] page;
  } blit_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = '0;
  logic [6:0] in_origin_x = '0;
  logic [5:0] in_origin_y = '0;
  logic [7:0] in_region_width = '0;
  logic [6:0] in_region_height = '0;
  logic       in_set_pixels = 1'b0;
  logic [7:0] in_bitmap_byte = '0;
  logic [6:0] in_read_column = '0;
  logic [2:0] in_read_page = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_region_finished;
  logic [1:0] out_status;

  // predicted framebuffer and walk state
  logic [7:0] frame_model [SCREEN_COLUMNS * SCREEN_PAGES];
  int         walk_col = 0;
  int         walk_row = 0;
  int         area_x = 0;
  int         area_y = 0;
  int         area_w = 0;
  int         area_h = 0;
  bit         area_set = 1'b0;
  bit         area_open = 1'b0;

  result_t    pending_results [$];
  int         items_sent = 0;
  int         mismatches = 0;
  int         stuck_cycles = 0;
  bit         idle_enabled = 1'b1;
  bit         hold_request = 1'b0;

  monochrome_bitmap_blitter_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_origin_x        (in_origin_x),
    .in_origin_y        (in_origin_y),
    .in_region_width    (in_region_width),
    .in_region_height   (in_region_height),
    .in_set_pixels      (in_set_pixels),
    .in_bitmap_byte     (in_bitmap_byte),
    .in_read_column     (in_read_column),
    .in_read_page       (in_read_page),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_region_finished(out_region_finished),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t predict_blit_result(input blit_item_t it);
    result_t r;
    int      px;
    int      py;
    int      k;
    r.data = '0;
    r.finished = 1'b0;
    r.status = ST_OK;
    case (it.op)
      OP_START: begin
        area_x = it.origin_x;
        area_y = it.origin_y;
        area_w = it.width;
        area_h = it.height;
        area_set = it.set_mode;
        walk_col = 0;
        walk_row = 0;
        area_open = (area_w != 0) && (area_h != 0);
        r.finished = !area_open;
      end
      OP_BITMAP: begin
        if (!area_open) begin
          r.status = ST_NO_REGION;
        end else begin
          for (k = 0; k < MARKS_PER_BYTE && area_open; k++) begin
            if (it.marks[k]) begin
              px = area_x + walk_col;
              py = area_y + walk_row;
              if (px < SCREEN_COLUMNS && py < SCREEN_ROWS) begin
                frame_model[px * SCREEN_PAGES + py / ROWS_PER_PAGE][py % ROWS_PER_PAGE] = area_set;
              end else begin
                r.status = ST_OFFSCREEN;
              end
            end
            walk_row++;
            if (walk_row >= area_h) begin
              walk_row = 0;
              walk_col++;
              if (walk_col >= area_w) begin
                area_open = 1'b0;
                r.finished = 1'b1;
              end
            end
          end
        end
      end
      OP_READ: begin
        if (it.column < SCREEN_COLUMNS && it.page < SCREEN_PAGES) begin
          r.data = frame_model[it.column * SCREEN_PAGES + it.page];
        end else begin
          r.status = ST_OFFSCREEN;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // unused fields carry random junk
  function automatic blit_item_t junk_item(input op_t op);
    blit_item_t it;
    it.op = op;
    it.origin_x = 7'($urandom);
    it.origin_y = 6'($urandom);
    it.width = 8'($urandom);
    it.height = 7'($urandom);
    it.set_mode = 1'($urandom);
    it.marks = 8'($urandom);
    it.column = 7'($urandom);
    it.page = 3'($urandom);
    return it;
  endfunction

  function automatic blit_item_t start_item(input int x, input int y, input int w,
                                            input int h, input bit set_mode);
    blit_item_t it;
    it = junk_item(OP_START);
    it.origin_x = 7'(x);
    it.origin_y = 6'(y);
    it.width = 8'(w);
    it.height = 7'(h);
    it.set_mode = set_mode;
    return it;
  endfunction

  function automatic blit_item_t bitmap_item(input logic [7:0] marks);
    blit_item_t it;
    it = junk_item(OP_BITMAP);
    it.marks = marks;
    return it;
  endfunction

  function automatic blit_item_t read_item(input int column, input int page);
    blit_item_t it;
    it = junk_item(OP_READ);
    it.column = 7'(column);
    it.page = 3'(page);
    return it;
  endfunction

  function automatic blit_item_t region_read(input int x, input int y, input int w,
                                             input int h);
    return read_item((x + $urandom_range(0, w - 1)) % SCREEN_COLUMNS,
                     ((y + $urandom_range(0, h - 1)) / ROWS_PER_PAGE) % SCREEN_PAGES);
  endfunction

  task automatic send_item(input blit_item_t it);
    if (idle_enabled) begin
      while ($urandom_range(0, 99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_origin_x <= it.origin_x;
    in_origin_y <= it.origin_y;
    in_region_width <= it.width;
    in_region_height <= it.height;
    in_set_pixels <= it.set_mode;
    in_bitmap_byte <= it.marks;
    in_read_column <= it.column;
    in_read_page <= it.page;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_blit_result(it));
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_random_blits(input int count);
    int   stop_at;
    int   style;
    int   w;
    int   h;
    int   ox;
    int   oy;
    int   nbytes;
    int   nsend;
    int   density;
    int   k;
    bit   set_mode;
    logic [7:0] marks;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      style = $urandom_range(0, 99);
      if (style < 8) begin
        send_item(junk_item(op_t'($urandom_range(0, 3))));
      end else if (style < 18) begin
        send_item(read_item($urandom_range(0, SCREEN_COLUMNS - 1),
                            $urandom_range(0, SCREEN_PAGES - 1)));
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            w = $urandom_range(1, SCREEN_COLUMNS);
            h = $urandom_range(1, 4);
          end
          1: begin
            w = $urandom_range(1, 3);
            h = $urandom_range(1, SCREEN_ROWS);
          end
          default: begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 20);
          end
        endcase
        ox = $urandom_range(0, SCREEN_COLUMNS - 1);
        oy = $urandom_range(0, SCREEN_ROWS - 1);
        set_mode = 1'($urandom);
        nbytes = (w * h + MARKS_PER_BYTE - 1) / MARKS_PER_BYTE;
        case ($urandom_range(0, 9))
          0: nsend = $urandom_range(0, nbytes - 1);
          1: nsend = nbytes + $urandom_range(1, 2);
          default: nsend = nbytes;
        endcase
        density = $urandom_range(0, 3);
        send_item(start_item(ox, oy, w, h, set_mode));
        for (k = 0; k < nsend; k++) begin
          case (density)
            0: marks = 8'hFF;
            1: marks = 8'($urandom & $urandom);
            default: marks = 8'($urandom);
          endcase
          send_item(bitmap_item(marks));
          if ($urandom_range(0, 99) < 12) begin
            send_item(region_read(ox, oy, w, h));
          end
        end
        repeat ($urandom_range(1, 3)) send_item(region_read(ox, oy, w, h));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(read_item(0, 0));
    send_item(read_item(127, 7));
    send_item(bitmap_item(8'hA5));
    send_item(start_item(0, 0, 1, 1, 1'b1));
    send_item(bitmap_item(8'hFF));
    send_item(read_item(0, 0));
    send_item(start_item(127, 56, 1, 8, 1'b1));
    send_item(bitmap_item(8'hFF));
    send_item(read_item(127, 7));
    // region running off the right and bottom edges
    send_item(start_item(126, 60, 4, 8, 1'b1));
    send_item(bitmap_item(8'hFF));
    send_item(bitmap_item(8'h00));
    send_item(bitmap_item(8'hFF));
    send_item(bitmap_item(8'h0F));
    send_item(read_item(126, 7));
    // empty regions
    send_item(start_item(5, 5, 0, 9, 1'b1));
    send_item(start_item(5, 5, 9, 0, 1'b1));
    send_item(bitmap_item(8'h3C));
    // restart abandons the open region
    send_item(start_item(10, 3, 3, 5, 1'b1));
    send_item(bitmap_item(8'hFF));
    send_item(start_item(10, 3, 2, 2, 1'b0));
    send_item(bitmap_item(8'h0F));
    send_item(read_item(10, 0));
    send_item(junk_item(OP_NONE));
    send_item(start_item(127, 63, 255, 127, 1'b1));
    send_item(bitmap_item(8'hFF));
    send_item(start_item(0, 0, 1, 1, 1'b0));
    send_item(bitmap_item(8'h01));
    send_item(read_item(0, 0));
  endtask

  task automatic test_random_blits();
    run_random_blits(450);
  endtask

  task automatic test_no_idling();
    idle_enabled = 1'b0;
    run_random_blits(120);
    idle_enabled = 1'b1;
  endtask

  task automatic test_result_backpressure();
    hold_request = 1'b1;
    run_random_blits(80);
  endtask

  task automatic test_sender_pause();
    run_random_blits(40);
    wait_for_results();
    run_random_blits(40);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= idle_enabled && ($urandom_range(0, 99) < 24);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.data) begin
          $error("read_data: expected %0h, got %0h", want.data, out_read_data);
          mismatches++;
        end
        if (out_region_finished !== want.finished) begin
          $error("region_finished: expected %0d, got %0d", want.finished,
                 out_region_finished);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
      end
    end
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (frame_model[i]) frame_model[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_blits();
    test_no_idling();
    test_result_backpressure();
    test_sender_pause();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
